[hw/rtl/chacha20_keystream_block_assert.svh]
// ----------------------------------------------------------------------------
// ChaCha20 keystream block assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_BLOCK_ASSERT_SVH
`define CHACHA20_KEYSTREAM_BLOCK_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define CCKS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CCKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ccks_pkg.sv]
// ----------------------------------------------------------------------------
// ChaCha20 keystream package
// Word and block types, the expansion constants and the quarter round.
// ----------------------------------------------------------------------------
package ccks_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;
	typedef logic [7:0][63:0] pairs_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	// Result handed from the round engine to the output stage.
	typedef struct packed {
		logic  valid;
		word_t counter;
	} core_res_t;

	typedef enum logic [2:0] {
		CFG_KEY_01   = 3'd0,
		CFG_KEY_23   = 3'd1,
		CFG_KEY_45   = 3'd2,
		CFG_KEY_67   = 3'd3,
		CFG_NONCE_01 = 3'd4,
		CFG_NONCE_2  = 3'd5
	} cfg_idx_t;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	localparam logic [2:0] LAST_PAIR = 3'd7;
	localparam int unsigned COUNTER_WORD = 12;

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic quad_t quarter(quad_t q);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		a = q.a;
		b = q.b;
		c = q.c;
		d = q.d;
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		return '{a: a, b: b, c: c, d: d};
	endfunction

endpackage

[hw/rtl/ccks_front.sv]
// ----------------------------------------------------------------------------
// ChaCha20 keystream front end
// Two-entry queue that takes counter transactions and feeds the round engine.
// ----------------------------------------------------------------------------
`include "chacha20_keystream_block_assert.svh"

module ccks_front
	import ccks_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  word_t s_counter,
	output logic  q_valid,
	output word_t q_counter,
	input  logic  q_pop
);

	word_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_counter = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= s_counter;
		end
	end

	`CCKS_ASSERT(a_front_no_overfill, cnt_q <= 2'd2, "front queue count beyond depth")

endmodule

[hw/rtl/ccks_core.sv]
// ----------------------------------------------------------------------------
// ChaCha20 round engine
// Iterative engine: one column or diagonal round of four quarter rounds a cycle.
// ----------------------------------------------------------------------------
`include "chacha20_keystream_block_assert.svh"

module ccks_core
	import ccks_pkg::*;
#(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  word_t     q_counter,
	output logic      q_pop,
	input  block_t    init_words,
	input  logic      out_ready,
	output core_res_t res,
	output block_t    mix
);

	localparam int unsigned ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int unsigned RW     = $clog2(ROUNDS);

	block_t        mix_q;
	block_t        mix_d;
	block_t        start_words;
	word_t         counter_q;
	logic [RW-1:0] rnd_q;
	logic          busy_q;
	logic          done_q;
	logic          start;
	logic          last_rnd;
	logic          diag;

	assign start    = q_valid && !busy_q && (!done_q || out_ready);
	assign q_pop    = start;
	assign last_rnd = (rnd_q == RW'(ROUNDS - 1));
	assign diag     = rnd_q[0];

	always_comb begin
		start_words               = init_words;
		start_words[COUNTER_WORD] = q_counter;
	end

	// The diagonal round is the column round with rows one to three rotated
	// left by one, two and three places.
	always_comb begin
		quad_t qi;
		quad_t qo;
		mix_d = mix_q;
		for (int i = 0; i < 4; i++) begin
			qi.a = mix_q[i];
			qi.b = diag ? mix_q[4 + ((i + 1) & 3)]  : mix_q[4 + i];
			qi.c = diag ? mix_q[8 + ((i + 2) & 3)]  : mix_q[8 + i];
			qi.d = diag ? mix_q[12 + ((i + 3) & 3)] : mix_q[12 + i];
			qo = quarter(qi);
			mix_d[i] = qo.a;
			if (diag) begin
				mix_d[4 + ((i + 1) & 3)]  = qo.b;
				mix_d[8 + ((i + 2) & 3)]  = qo.c;
				mix_d[12 + ((i + 3) & 3)] = qo.d;
			end else begin
				mix_d[4 + i]  = qo.b;
				mix_d[8 + i]  = qo.c;
				mix_d[12 + i] = qo.d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else if (busy_q) begin
			if (last_rnd) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				rnd_q <= rnd_q + 1'b1;
			end
		end else if (done_q && out_ready) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mix_q     <= start_words;
			counter_q <= q_counter;
		end else if (busy_q) begin
			mix_q <= mix_d;
		end
	end

	assign res.valid   = done_q;
	assign res.counter = counter_q;
	assign mix         = mix_q;

	`CCKS_ASSERT(a_core_busy_not_done, !(busy_q && done_q), "engine busy and done together")
	`CCKS_ASSERT_NEXT(a_core_round_step, busy_q && !last_rnd,
		busy_q && (rnd_q == $past(rnd_q) + 1'b1), "round counter skipped a round")

endmodule

[hw/rtl/ccks_out.sv]
// ----------------------------------------------------------------------------
// ChaCha20 keystream output stage
// Adds the starting words back in and sends the block as eight 64-bit beats.
// ----------------------------------------------------------------------------
`include "chacha20_keystream_block_assert.svh"

module ccks_out
	import ccks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  core_res_t   res,
	input  block_t      mix,
	input  block_t      init_words,
	output logic        out_ready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	pairs_t     pairs_q;
	block_t     sum;
	logic [2:0] beat_q;
	logic       full_q;
	logic       load;
	logic       take;

	always_comb begin
		for (int w = 0; w < 16; w++) begin
			sum[w] = mix[w] + ((w == COUNTER_WORD) ? res.counter : init_words[w]);
		end
	end

	assign take      = full_q && m_tready;
	assign out_ready = !full_q || (m_tready && (beat_q == LAST_PAIR));
	assign load      = res.valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			beat_q <= 3'd0;
		end else if (load) begin
			full_q <= 1'b1;
			beat_q <= 3'd0;
		end else if (take) begin
			beat_q <= beat_q + 3'd1;
			if (beat_q == LAST_PAIR) begin
				full_q <= 1'b0;
			end
		end
	end

	// Pair k of the block sits at word positions 2k and 2k+1, so the block
	// register doubles as a shift line of 64-bit beats.
	always_ff @(posedge clk) begin
		if (load) begin
			pairs_q <= pairs_t'(sum);
		end else if (take) begin
			pairs_q <= {64'd0, pairs_q[7:1]};
		end
	end

	assign m_tvalid = full_q;
	assign m_tdata  = pairs_q[0];
	assign m_tuser  = beat_q;
	assign m_tlast  = (beat_q == LAST_PAIR);

	`CCKS_ASSERT_NEXT(a_out_load_starts, load, full_q && (beat_q == 3'd0),
		"loaded block does not start at its first pair")
	`CCKS_ASSERT_NEXT(a_out_mid_block, take && (beat_q != LAST_PAIR), full_q,
		"output emptied before the last pair")

endmodule

[hw/rtl/chacha20_keystream_block.sv]
// The round engine does one column or diagonal round a cycle and mixes one block
// at a time; each finished block then leaves the output stage as eight beats.
// Output beats drain while the next block is mixed; a two-entry queue holds counters.
// Reset: asynchronous, active low; clears key and nonce registers, queue and engine.
// ----------------------------------------------------------------------------
// ChaCha20 keystream block generator
// Configuration registers, queue, round engine and output stage.
// ----------------------------------------------------------------------------
module chacha20_keystream_block
	import ccks_pkg::*;
#(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] block_counter
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [63:0] keystream_pair
	output logic [2:0]  m_tuser,  // [2:0] pair_index
	output logic        m_tlast   // last_pair
);

	logic [63:0] key01_q;
	logic [63:0] key23_q;
	logic [63:0] key45_q;
	logic [63:0] key67_q;
	logic [63:0] nonce01_q;
	word_t       nonce2_q;
	block_t      init_words;
	logic        q_valid;
	word_t       q_counter;
	logic        q_pop;
	logic        out_ready;
	core_res_t   res;
	block_t      mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q   <= '0;
			key23_q   <= '0;
			key45_q   <= '0;
			key67_q   <= '0;
			nonce01_q <= '0;
			nonce2_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KEY_01:   key01_q   <= cfg_data;
				CFG_KEY_23:   key23_q   <= cfg_data;
				CFG_KEY_45:   key45_q   <= cfg_data;
				CFG_KEY_67:   key67_q   <= cfg_data;
				CFG_NONCE_01: nonce01_q <= cfg_data;
				CFG_NONCE_2:  nonce2_q  <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// The counter word is left at zero here and filled in by the engine.
	assign init_words = {nonce2_q, nonce01_q, 32'd0, key67_q, key45_q, key23_q, key01_q,
		SIGMA3, SIGMA2, SIGMA1, SIGMA0};

	ccks_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_counter (s_tdata),
		.q_valid   (q_valid),
		.q_counter (q_counter),
		.q_pop     (q_pop)
	);

	ccks_core #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_counter  (q_counter),
		.q_pop      (q_pop),
		.init_words (init_words),
		.out_ready  (out_ready),
		.res        (res),
		.mix        (mix)
	);

	ccks_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.mix        (mix),
		.init_words (init_words),
		.out_ready  (out_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 keystream block testbench
// Drives block counters under several key and nonce settings, with random
// gaps on the counter stream and random back-pressure on the keystream
// stream. Every keystream beat is compared with a local block function.
// ----------------------------------------------------------------------------
module tb_top
	import ccks_pkg::*;
();

	localparam int unsigned DOUBLE_ROUNDS = 10;
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned MAX_WAIT      = 12;
	localparam int unsigned PRINT_LIMIT   = 40;
	localparam logic [2:0]  CFG_UNUSED_6  = 3'd6;
	localparam logic [2:0]  CFG_UNUSED_7  = 3'd7;

	typedef logic [15:0][31:0] chacha_words_t;

	typedef struct packed {
		logic [63:0] pair;
		logic [2:0]  pair_idx;
		logic        last;
	} ks_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] block_counter
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;  // [63:0] keystream_pair
	logic [2:0]  m_tuser;  // [2:0] pair_index
	logic        m_tlast;  // last_pair

	logic [63:0] key_nonce_regs [0:5];
	ks_beat_t    expected_beats [$];
	int unsigned mismatches;
	int unsigned idle_cycles;
	bit          sender_gaps;
	bit          receiver_stalls;

	chacha20_keystream_block #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] rotate_left(logic [31:0] v, int unsigned n);
		logic [63:0] twice;
		twice = {v, v} << n;
		return twice[63:32];
	endfunction

	function automatic chacha_words_t mix_quarter(chacha_words_t s, int unsigned a,
			int unsigned b, int unsigned c, int unsigned d);
		s[a] = s[a] + s[b]; s[d] = rotate_left(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotate_left(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotate_left(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotate_left(s[b] ^ s[c], 7);
		return s;
	endfunction

	// Full block function: initial matrix, double rounds, then the feed-forward add.
	function automatic chacha_words_t keystream_words(logic [31:0] counter);
		chacha_words_t init_m;
		chacha_words_t mix_m;
		init_m[0] = SIGMA0;
		init_m[1] = SIGMA1;
		init_m[2] = SIGMA2;
		init_m[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_m[4 + 2 * i] = key_nonce_regs[i][31:0];
			init_m[5 + 2 * i] = key_nonce_regs[i][63:32];
		end
		init_m[12] = counter;
		init_m[13] = key_nonce_regs[CFG_NONCE_01][31:0];
		init_m[14] = key_nonce_regs[CFG_NONCE_01][63:32];
		init_m[15] = key_nonce_regs[CFG_NONCE_2][31:0];
		mix_m = init_m;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			mix_m = mix_quarter(mix_m, 0, 4, 8, 12);
			mix_m = mix_quarter(mix_m, 1, 5, 9, 13);
			mix_m = mix_quarter(mix_m, 2, 6, 10, 14);
			mix_m = mix_quarter(mix_m, 3, 7, 11, 15);
			mix_m = mix_quarter(mix_m, 0, 5, 10, 15);
			mix_m = mix_quarter(mix_m, 1, 6, 11, 12);
			mix_m = mix_quarter(mix_m, 2, 7, 8, 13);
			mix_m = mix_quarter(mix_m, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			mix_m[i] = mix_m[i] + init_m[i];
		return mix_m;
	endfunction

	task automatic queue_block_beats(input logic [31:0] counter);
		chacha_words_t w;
		ks_beat_t      b;
		w = keystream_words(counter);
		for (int k = 0; k < 8; k++) begin
			b.pair     = {w[2 * k + 1], w[2 * k]};
			b.pair_idx = k[2:0];
			b.last     = (k[2:0] == LAST_PAIR);
			expected_beats.push_back(b);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
	endtask

	// The counter stream is held off during a write so that no counter is
	// accepted while the key changes; the tests drain the block before writing.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		s_tvalid  = 1'b0;
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx <= CFG_NONCE_2) begin
			if (idx == CFG_NONCE_2)
				value[63:32] = '0;
			key_nonce_regs[idx] = value;
		end
	endtask

	task automatic write_key_nonce(input logic [63:0] k01, input logic [63:0] k23,
			input logic [63:0] k45, input logic [63:0] k67,
			input logic [63:0] n01, input logic [63:0] n2);
		write_reg(CFG_KEY_01, k01);
		write_reg(CFG_KEY_23, k23);
		write_reg(CFG_KEY_45, k45);
		write_reg(CFG_KEY_67, k67);
		write_reg(CFG_NONCE_01, n01);
		write_reg(CFG_NONCE_2, n2);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// Returns at the rising edge that accepts the counter, with tvalid still
	// high, so that a following call without a gap keeps the stream busy.
	task automatic send_counter(input logic [31:0] counter);
		int unsigned gap;
		gap = sender_gaps ? $urandom_range(0, MAX_WAIT) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = counter;
		do @(posedge clk); while (!s_tready);
		queue_block_beats(counter);
	endtask

	// Keystream sink: a fresh stall is drawn before every beat.
	initial begin : keystream_sink
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = receiver_stalls ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : check_beats
		ks_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("beat with nothing outstanding", m_tdata, '0);
			end else begin
				want = expected_beats.pop_front();
				if (m_tdata !== want.pair)
					report_mismatch("keystream_pair", m_tdata, want.pair);
				if (m_tuser !== want.pair_idx)
					report_mismatch("pair_index", 64'(m_tuser), 64'(want.pair_idx));
				if (m_tlast !== want.last)
					report_mismatch("last_pair", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// All-zero key and nonce straight out of reset, counters at the extremes.
	task automatic test_reset_key();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		send_counter(32'h0000_0000);
		send_counter(32'h0000_0001);
		send_counter(32'hFFFF_FFFF);
		receiver_stalls = 1'b1;
		send_counter(32'h8000_0000);
		send_counter(32'h5555_5555);
		send_counter(32'hAAAA_AAAA);
		wait_drained();
	endtask

	// Key 00..1f, nonce 00 00 00 09 00 00 00 4a 00 00 00 00, counter 1: the
	// published block function vector.
	task automatic test_published_vector();
		write_key_nonce(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
			64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
			64'h4a00_0000_0900_0000, 64'h0000_0000_0000_0000);
		sender_gaps = 1'b1;
		send_counter(32'h0000_0001);
		send_counter(32'h0000_0002);
		wait_drained();
	endtask

	// Every key and nonce bit set; the top half of the last nonce word is
	// written too and must be dropped.
	task automatic test_all_ones();
		write_key_nonce('1, '1, '1, '1, '1, '1);
		sender_gaps = 1'b0;
		send_counter(32'h0000_0000);
		send_counter(32'hFFFF_FFFF);
		send_counter(32'h7FFF_FFFF);
		wait_drained();
	endtask

	// Writes to the two unused indexes must leave the key and nonce alone.
	task automatic test_unused_index();
		write_reg(CFG_NONCE_2, 64'hDEAD_BEEF_1234_5678);
		write_reg(CFG_UNUSED_6, {$urandom, $urandom});
		write_reg(CFG_UNUSED_7, {$urandom, $urandom});
		write_reg(CFG_UNUSED_6, '1);
		write_reg(CFG_UNUSED_7, '0);
		sender_gaps = 1'b1;
		send_counter(32'h1234_5678);
		send_counter($urandom);
		wait_drained();
	endtask

	// Runs of counters that mostly increment, as a cipher would use them,
	// with random keys and an occasional jump to an extreme or to a random value.
	task automatic test_random_traffic();
		logic [31:0] base;
		logic [31:0] counter;
		int unsigned pick;
		for (int phase = 0; phase < 5; phase++) begin
			write_key_nonce({$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			if (phase == 2)
				write_reg(3'($urandom_range(CFG_UNUSED_6, CFG_UNUSED_7)),
					{$urandom, $urandom});
			sender_gaps     = (phase != 1);
			receiver_stalls = (phase != 3);
			base = (phase == 4) ? 32'hFFFF_FFF0 : $urandom;
			for (int n = 0; n < 24; n++) begin
				pick = $urandom_range(0, 15);
				if (pick == 0)
					counter = 32'h0000_0000;
				else if (pick == 1)
					counter = 32'hFFFF_FFFF;
				else if (pick == 2)
					counter = $urandom;
				else
					counter = base + n;
				if (phase == 2 && n == 13)
					wait_drained();
				send_counter(counter);
			end
			wait_drained();
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_KEY_01;
		cfg_data        = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		for (int i = 0; i < 6; i++)
			key_nonce_regs[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_key();
		test_published_vector();
		test_all_ones();
		test_unused_index();
		test_random_traffic();

		wait_drained();
		repeat (2 * DOUBLE_ROUNDS + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
